/* rtl/longest_prefix_route_table_core_assert.svh */
// Assertion macros for the longest-prefix route table checker.
// Used by the port checker only; no other dependencies.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_CORE_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_CORE_ASSERT_SVH
// Assert an implication in the next cycle, held off during reset.
`define LPRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert an implication in the same cycle, held off during reset.
`define LPRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/lprt_pkg.sv */
// Shared types and constants for the longest-prefix route table.
// No dependencies.
package lprt_pkg;
  localparam int ModeW = 3;
  localparam int LenW = 8;
  localparam int InTagW = 16;
  localparam int StatusW = 2;

  localparam logic [ModeW-1:0] MODE_INS4 = 3'd0;
  localparam logic [ModeW-1:0] MODE_INS6 = 3'd1;
  localparam logic [ModeW-1:0] MODE_LOOK4 = 3'd2;
  localparam logic [ModeW-1:0] MODE_LOOK6 = 3'd3;
  localparam logic [ModeW-1:0] MODE_CLEAR = 3'd4;

  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_LEN = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  localparam logic [LenW-1:0] MaxLen4 = 8'd32;
  localparam logic [LenW-1:0] MaxLen6 = 8'd128;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the input item
    logic insert;   // write the captured entry into the table
    logic clear;    // empty the table
    logic finish;   // register the result
  } lprt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_insert;
    logic insert_ok;
  } lprt_stat_t;

  // 128-bit prefix mask for a length 0..128.
  function automatic logic [127:0] mask128(input logic [LenW-1:0] len);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 128; b++) begin
      m[127-b] = (LenW'(b) < len);
    end
    return m;
  endfunction

  // 32-bit prefix mask for a length 0..32.
  function automatic logic [31:0] mask32(input logic [LenW-1:0] len);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      m[31-b] = (LenW'(b) < len);
    end
    return m;
  endfunction
endpackage

/* rtl/lprt_ctrl.sv */
// Controller state machine for the route table: sequences capture and work.
// Depends on lprt_pkg.
module lprt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lprt_pkg::lprt_cmd_t cmd
);
  import lprt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Take an item once the result register is free or being drained.
  assign in_ready = (state == S_IDLE) || (state == S_DONE && out_ready);
  assign out_valid = (state == S_DONE);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.load = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_WORK;
      end
      S_WORK: begin
        cmd.insert = 1'b1;
        cmd.clear = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = in_valid ? S_WORK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

/* rtl/lprt_datapath.sv */
// Datapath of the route table: per-entry cells, match chain and insert shift.
// Depends on lprt_pkg.
module lprt_datapath #(
  parameter int ENTRIES = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lprt_pkg::lprt_cmd_t         cmd,
  input  logic [lprt_pkg::ModeW-1:0]  mode,
  input  logic [63:0]                 addr_hi,
  input  logic [63:0]                 addr_lo,
  input  logic [lprt_pkg::LenW-1:0]   pfx_len,
  input  logic [lprt_pkg::InTagW-1:0] route_tag,
  output logic                        hit,
  output logic [15:0]                 match_tag,
  output logic [lprt_pkg::StatusW-1:0] status
);
  import lprt_pkg::*;

  localparam int CntW = $clog2(ENTRIES + 1);

  // Captured item.
  logic [ModeW-1:0]  q_mode;
  logic [127:0]      q_addr;
  logic [LenW-1:0]   q_len;
  logic [InTagW-1:0] q_tag;

  // Entry cells.
  logic [127:0]        e_addr [ENTRIES];
  logic [LenW-1:0]     e_len  [ENTRIES];
  logic                e_six  [ENTRIES];
  logic [TAG_BITS-1:0] e_tag  [ENTRIES];
  logic [CntW-1:0]     count;

  logic six, bad, full;
  logic [127:0] mask, ins_addr;
  logic [TAG_BITS-1:0] ins_tag;
  logic [ENTRIES-1:0] shorter, matched;
  logic [TAG_BITS-1:0] found_tag;
  logic found;
  logic [CntW-1:0] ins_pos;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_mode <= mode;
      q_addr <= {addr_hi, addr_lo};
      q_len <= pfx_len;
      q_tag <= route_tag;
    end
  end

  // Decode the captured item and build the masked entry.
  always_comb begin
    six = (q_mode == MODE_INS6) || (q_mode == MODE_LOOK6);
    bad = q_len > (six ? MaxLen6 : MaxLen4);
    full = (count == CntW'(ENTRIES));
    mask = six ? mask128(q_len) : {96'd0, mask32(q_len)};
    ins_addr = q_addr & mask;
    if (!six) ins_addr[127:32] = '0;
    ins_tag = TAG_BITS'(q_tag);
  end

  // Per-cell compares: shorter-than for insert, prefix match for lookup.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic [127:0] m;
      logic [127:0] a;
      m = e_six[i] ? mask128(e_len[i]) : {96'd0, mask32(e_len[i])};
      a = e_six[i] ? q_addr : {96'd0, q_addr[31:0]};
      shorter[i] = (CntW'(i) < count) && (q_len > e_len[i]);
      matched[i] = (CntW'(i) < count) && (e_six[i] == six) &&
                   ((a & m) == (e_addr[i] & m));
    end
  end

  // Priority pick of the first matching cell.
  always_comb begin
    found = 1'b0;
    found_tag = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (matched[i]) begin
        found = 1'b1;
        found_tag = e_tag[i];
      end
    end
  end

  // Insert slot: first shorter cell, or the end of the table when none.
  always_comb begin
    ins_pos = count;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shorter[i]) ins_pos = CntW'(i);
    end
  end

  wire do_ins = cmd.insert && (q_mode == MODE_INS4 || q_mode == MODE_INS6) && !bad && !full;

  // Shift shorter cells down one place and drop the new entry in the gap.
  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (shorter[i - 1]) begin
          e_addr[i] <= e_addr[i - 1];
          e_len[i] <= e_len[i - 1];
          e_six[i] <= e_six[i - 1];
          e_tag[i] <= e_tag[i - 1];
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (CntW'(i) == ins_pos) begin
          e_addr[i] <= ins_addr;
          e_len[i] <= q_len;
          e_six[i] <= six;
          e_tag[i] <= ins_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.clear && q_mode == MODE_CLEAR) count <= '0;
    else if (do_ins) count <= count + 1'b1;
  end

  // Register the result.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (q_mode)
        MODE_INS4, MODE_INS6: begin
          hit <= 1'b0;
          match_tag <= '0;
          status <= bad ? ST_BAD_LEN : (full ? ST_FULL : ST_OK);
        end
        MODE_LOOK4, MODE_LOOK6: begin
          hit <= found;
          match_tag <= 16'(found_tag);
          status <= ST_OK;
        end
        default: begin
          hit <= 1'b0;
          match_tag <= '0;
          status <= ST_OK;
        end
      endcase
    end
  end
endmodule

/* rtl/longest_prefix_route_table_core.sv */
// Longest-prefix route table: one item in, one result out.
// An item is captured on its transfer, worked in S_WORK, and its result is registered into S_DONE.
// Items are taken only when idle or while the result drains, not during the single compare/shift pass over the cells.
// Reset: rst (synchronous) empties the table and drops any pending result.
// Depends on lprt_pkg, lprt_ctrl and lprt_datapath.
module longest_prefix_route_table_core #(
  parameter int ENTRIES = 64,
  parameter int TAG_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0: mode[2:0], addr_hi[66:3], addr_lo[130:67],
  // pfx_len[138:131], route_tag[154:139], zero fill to 160
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0: hit[0], match_tag[16:1], status[18:17], zero fill to 24
  output logic [23:0]  m_tdata
);
  import lprt_pkg::*;

  lprt_cmd_t cmd;
  logic hit;
  logic [15:0] match_tag;
  logic [StatusW-1:0] status;

  lprt_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd
  );

  lprt_datapath #(.ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS)) u_dp (
    .clk, .rst, .cmd,
    .mode(s_tdata[2:0]), .addr_hi(s_tdata[66:3]), .addr_lo(s_tdata[130:67]),
    .pfx_len(s_tdata[138:131]), .route_tag(s_tdata[154:139]),
    .hit, .match_tag, .status
  );

  assign m_tdata = {5'd0, status, match_tag, hit};
endmodule

/* rtl/lprt_checker.sv */
// Port checker for the route table core, bound to the top level.
// Depends on longest_prefix_route_table_core_assert.svh.
`include "longest_prefix_route_table_core_assert.svh"
module lprt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [23:0]  m_tdata
);
  `LPRT_ASSERT_NEXT(a_res_after_in, s_tvalid && s_tready, !m_tvalid ##1 m_tvalid)
  `LPRT_ASSERT_NOW(a_no_in_when_blocked, m_tvalid && !m_tready, !s_tready)
  `LPRT_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[18:17] != 2'd3)
  `LPRT_ASSERT_NOW(a_hit_no_status, m_tvalid && m_tdata[0], m_tdata[18:17] == 2'd0)
endmodule

bind longest_prefix_route_table_core lprt_checker u_lprt_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

/* test/tb_longest_prefix_route_table_core.sv */
// Testbench for the longest-prefix route table core: directed table, a fill to capacity, then random items.
// Checks each result against a behavioral table predictor or a literal expectation. Depends on lprt_pkg and the core.
module tb_longest_prefix_route_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lprt_pkg::*;

  localparam int Depth = 64;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0] len;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [2:0] mode;
  } route_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] tag;
    logic hit;
  } route_rsp_t;

  // directed row: request, and whether a literal expectation is given
  typedef struct {
    route_req_t req;
    bit fixed;
    route_rsp_t rsp;
  } dir_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [159:0] s_tdata;
  logic [23:0] m_tdata;

  longest_prefix_route_table_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state: table ordered by decreasing length
  logic [63:0] rt_hi[Depth];
  logic [63:0] rt_lo[Depth];
  logic [7:0] rt_len[Depth];
  logic rt_six[Depth];
  logic [15:0] rt_tag[Depth];
  int rt_count;

  route_rsp_t pending_rsp[$];
  int errors;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] prefix_mask(input logic [7:0] len, input bit six);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 128; b++) m[127-b] = (b < len);
    if (!six) m = {96'd0, m[127:96]};
    return m;
  endfunction

  function automatic route_rsp_t route_predict(input route_req_t r);
    route_rsp_t o;
    logic [127:0] a, m;
    bit six;
    int i;
    o = '0;
    six = r.mode[0];
    a = six ? {r.hi, r.lo} : {96'd0, r.lo[31:0]};
    case (r.mode)
      MODE_INS4, MODE_INS6: begin
        if (r.len > (six ? MaxLen6 : MaxLen4)) o.status = ST_BAD_LEN;
        else if (rt_count >= Depth) o.status = ST_FULL;
        else begin
          a = a & prefix_mask(r.len, six);
          i = rt_count;
          // shift strictly shorter entries down
          while (i > 0 && r.len > rt_len[i-1]) begin
            rt_hi[i] = rt_hi[i-1]; rt_lo[i] = rt_lo[i-1]; rt_len[i] = rt_len[i-1];
            rt_six[i] = rt_six[i-1]; rt_tag[i] = rt_tag[i-1];
            i--;
          end
          rt_hi[i] = a[127:64]; rt_lo[i] = a[63:0]; rt_len[i] = r.len;
          rt_six[i] = six; rt_tag[i] = r.tag;
          rt_count++;
        end
      end
      MODE_LOOK4, MODE_LOOK6: begin
        for (i = 0; i < rt_count; i++) begin
          if (rt_six[i] == six) begin
            m = prefix_mask(rt_len[i], six);
            if ((a & m) == ({rt_hi[i], rt_lo[i]} & m)) begin
              o.hit = 1;
              o.tag = rt_tag[i];
              break;
            end
          end
        end
      end
      MODE_CLEAR: rt_count = 0;
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stall, compare each result transfer
  always @(posedge clk) begin
    route_rsp_t got, want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[18:0];
        if (m_tdata[23:19] != 0) report_mismatch("fill", 64'(m_tdata[23:19]), 64'd0);
        if (pending_rsp.size() == 0) report_mismatch("unexpected result", 64'(got), 64'd0);
        else begin
          want = pending_rsp.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.tag !== want.tag)
            report_mismatch("match_tag", 64'(got.tag), 64'(want.tag));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // drive one item, with random idle before it
  task automatic send_item(input route_req_t r, input bit fixed, input route_rsp_t rsp);
    route_rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = route_predict(r);
    pending_rsp.push_back(fixed ? rsp : p);
  endtask

  function automatic route_req_t make_req(input logic [2:0] mode, input logic [63:0] hi,
                                          input logic [63:0] lo, input logic [7:0] len,
                                          input logic [15:0] tag);
    route_req_t r;
    r.mode = mode; r.hi = hi; r.lo = lo; r.len = len; r.tag = tag;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random item: mostly inserts with valid lengths and lookups near stored prefixes
  function automatic route_req_t rand_req();
    route_req_t r;
    logic [127:0] pm;
    int k, pick;
    r = make_req(3'($urandom_range(3)), rand64(), rand64(), 8'd0, 16'($urandom()));
    k = $urandom_range(99);
    if (k < 3) r.mode = MODE_CLEAR;
    else if (k < 5) r.mode = 3'($urandom_range(5, 7));
    r.len = r.mode[0] ? 8'($urandom_range(128)) : 8'($urandom_range(32));
    if ($urandom_range(19) == 0) r.len = 8'($urandom());
    // reuse a stored prefix for lookups, randomizing bits past it
    if (r.mode inside {MODE_LOOK4, MODE_LOOK6} && rt_count > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(rt_count - 1);
      r.mode = rt_six[pick] ? MODE_LOOK6 : MODE_LOOK4;
      pm = prefix_mask(rt_len[pick], rt_six[pick]);
      if (rt_six[pick]) begin
        {r.hi, r.lo} = ({rt_hi[pick], rt_lo[pick]} & pm) | ({r.hi, r.lo} & ~pm);
      end else begin
        r.lo[31:0] = (rt_lo[pick][31:0] & pm[31:0]) | (r.lo[31:0] & ~pm[31:0]);
      end
    end
    return r;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    route_rsp_t none;
    route_req_t r;
    int phase;
    rt_count = 0;
    send_idle_pct = 34;
    recv_idle_pct = 68;
    s_tvalid = 0;
    s_tdata = '0;
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    none = '0;

    // directed rows
    rows.push_back('{make_req(MODE_LOOK4, 0, '1, 0, 0), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_LOOK6, '1, '1, 0, 0), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_INS4, 0, 0, 33, 16'h1), 1, '{ST_BAD_LEN, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_INS6, 0, 0, 129, 16'h1), 1, '{ST_BAD_LEN, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_INS6, 0, 0, 8'hFF, 16'h1), 1, '{ST_BAD_LEN, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_INS4, '1, '1, 0, 16'hFFFF), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_LOOK4, 0, 0, 0, 0), 1, '{ST_OK, 16'hFFFF, 1'b1}});
    rows.push_back('{make_req(MODE_LOOK6, 0, 0, 0, 0), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_INS6, '1, '1, 128, 16'hA5A5), 0, none});
    rows.push_back('{make_req(MODE_INS6, 64'h2001_0db8_0000_0000, 0, 32, 16'h0032), 0, none});
    rows.push_back('{make_req(MODE_INS6, 0, 0, 0, 16'h0600), 0, none});
    rows.push_back('{make_req(MODE_INS4, '1, 64'hFFFF_FFFF_C0A8_0101, 32, 16'h0020), 0, none});
    rows.push_back('{make_req(MODE_INS4, 0, 64'h0000_0000_C0A8_0000, 16, 16'h0010), 0, none});
    rows.push_back('{make_req(MODE_INS4, 0, 64'h0000_0000_C0A8_FFFF, 16, 16'h0011), 0, none});
    rows.push_back('{make_req(MODE_LOOK4, '1, 64'hABCD_0000_C0A8_0101, 0, 0), 0, none});
    rows.push_back('{make_req(MODE_LOOK4, 0, 64'h0000_0000_C0A8_7777, 0, 0), 0, none});
    rows.push_back('{make_req(MODE_LOOK4, 0, 64'h0000_0000_0A00_0001, 0, 0), 0, none});
    rows.push_back('{make_req(MODE_LOOK6, '1, '1, 0, 0), 0, none});
    rows.push_back('{make_req(MODE_LOOK6, 64'h2001_0db8_1234_0000, 5, 0, 0), 0, none});
    rows.push_back('{make_req(MODE_LOOK6, 64'h3000_0000_0000_0000, 0, 0, 0), 0, none});
    rows.push_back('{make_req(3'd5, '1, '1, 8'hFF, 16'hFFFF), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(3'd7, 0, 0, 0, 0), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_CLEAR, '1, '1, 8'hFF, 16'hFFFF), 1, '{ST_OK, 16'd0, 1'b0}});
    rows.push_back('{make_req(MODE_LOOK4, 0, 0, 0, 0), 1, '{ST_OK, 16'd0, 1'b0}});
    foreach (rows[i]) send_item(rows[i].req, rows[i].fixed, rows[i].rsp);

    // fill to capacity, then check the full and bad-length statuses
    for (int i = 0; i < Depth; i++)
      send_item(make_req(MODE_INS4, 64'd0, 64'($urandom()), 8'($urandom_range(32)),
                         16'($urandom())), 0, none);
    send_item(make_req(MODE_INS6, 0, 0, 5, 1), 1, '{ST_FULL, 16'd0, 1'b0});
    send_item(make_req(MODE_INS4, 0, 0, 33, 1), 1, '{ST_BAD_LEN, 16'd0, 1'b0});
    // hold off until every result is back
    wait_drained();
    send_item(make_req(MODE_CLEAR, 0, 0, 0, 0), 0, none);

    // random part in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < 530; n++) begin
        r = rand_req();
        send_item(r, 0, none);
      end
    end

    s_tvalid <= 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
